FILE: hw/rtl/dps_pkg.sv
// Shared types and constants for the drive distance PD step core.
package dps_pkg;

  // Field and datapath widths
  localparam int unsigned PosW    = 24;
  localparam int unsigned SumW    = 27;
  localparam int unsigned ErrW    = 25;
  localparam int unsigned DiffW   = 26;
  localparam int unsigned HeadW   = 16;
  localparam int unsigned TerrW   = 17;
  localparam int unsigned TdW     = 18;
  localparam int unsigned GainW   = 16;
  localparam int unsigned SlewW   = 16;
  localparam int unsigned Kp2W    = 10;
  localparam int unsigned MulAW   = 27;
  localparam int unsigned MulBW   = 28;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AccW    = 46;
  localparam int unsigned FracW   = 12;
  localparam int unsigned PowW    = AccW - FracW;
  localparam int unsigned PsumW   = PowW + 1;
  localparam int unsigned VoltW   = 5;
  localparam int unsigned CfgW    = 21;
  localparam int unsigned CfgIdxW = 3;

  // Divide by six: floor(m * DivSixRecip / 2^DivSixShift) is exact for m < 2^26
  localparam logic [MulBW-1:0] DivSixRecip = 28'd89478486;
  localparam int unsigned      DivSixShift = 29;

  // Extra proportional gains by error band, unsigned Q0.12 held in 10 bits
  localparam logic [Kp2W-1:0] Kp2Far  = 10'd205;
  localparam logic [Kp2W-1:0] Kp2Mid  = 10'd983;
  localparam logic [Kp2W-1:0] Kp2Near = 10'd451;

  localparam logic [SlewW-1:0] SlewStart = 16'd80;
  localparam logic [SlewW-1:0] SlewStep  = 16'd10;
  localparam logic [SlewW-1:0] SlewMax   = 16'd65535;

  localparam logic [GainW-1:0] GainPDistRst = 16'd569;
  localparam logic [GainW-1:0] GainDDistRst = 16'd1061;
  localparam logic [GainW-1:0] GainPHeadRst = 16'd1700;
  localparam logic [GainW-1:0] GainDHeadRst = 16'd0;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TGT_DIST  = 3'd0,
    REG_TGT_HEAD  = 3'd1,
    REG_GAIN_PD   = 3'd2,
    REG_GAIN_DD   = 3'd3,
    REG_GAIN_PH   = 3'd4,
    REG_GAIN_DH   = 3'd5
  } dps_reg_e;

  // Sequencer states, one-hot
  typedef enum logic [13:0] {
    ST_IDLE = 14'h0001,
    ST_SUM  = 14'h0002,
    ST_DIV  = 14'h0004,
    ST_ERR  = 14'h0008,
    ST_DIFF = 14'h0010,
    ST_M1   = 14'h0020,
    ST_M2   = 14'h0040,
    ST_M3   = 14'h0080,
    ST_M4   = 14'h0100,
    ST_M5   = 14'h0200,
    ST_M6   = 14'h0400,
    ST_TRN  = 14'h0800,
    ST_VOLT = 14'h1000,
    ST_OUT  = 14'h2000
  } dps_state_e;

  typedef struct packed {
    dps_state_e state;
    logic       ready;
    logic       load_out;
  } dps_ctrl_t;

endpackage

FILE: hw/rtl/dps_mul.sv
// Shared signed multiplier with registered product.
module dps_mul (
  input  logic                              clk_i,
  input  logic signed [dps_pkg::MulAW-1:0]  a_i,
  input  logic signed [dps_pkg::MulBW-1:0]  b_i,
  output logic signed [dps_pkg::ProdW-1:0]  prod_o
);

  logic signed [dps_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= dps_pkg::ProdW'(a_i) * dps_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/dps_ctrl.sv
// Step sequencer for the drive distance PD step core.
module dps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                tick_i,
  input  logic                out_free_i,
  output dps_pkg::dps_ctrl_t  ctrl_o
);

  dps_pkg::dps_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dps_pkg::ST_IDLE: if (in_valid_i) state_d = dps_pkg::ST_SUM;
      dps_pkg::ST_SUM:  state_d = dps_pkg::ST_DIV;
      dps_pkg::ST_DIV:  state_d = dps_pkg::ST_ERR;
      dps_pkg::ST_ERR:  state_d = dps_pkg::ST_DIFF;
      dps_pkg::ST_DIFF: state_d = tick_i ? dps_pkg::ST_M1 : dps_pkg::ST_OUT;
      dps_pkg::ST_M1:   state_d = dps_pkg::ST_M2;
      dps_pkg::ST_M2:   state_d = dps_pkg::ST_M3;
      dps_pkg::ST_M3:   state_d = dps_pkg::ST_M4;
      dps_pkg::ST_M4:   state_d = dps_pkg::ST_M5;
      dps_pkg::ST_M5:   state_d = dps_pkg::ST_M6;
      dps_pkg::ST_M6:   state_d = dps_pkg::ST_TRN;
      dps_pkg::ST_TRN:  state_d = dps_pkg::ST_VOLT;
      dps_pkg::ST_VOLT: state_d = dps_pkg::ST_OUT;
      dps_pkg::ST_OUT:  if (out_free_i) state_d = dps_pkg::ST_IDLE;
      default:          state_d = dps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.state    = state_q;
  assign ctrl_o.ready    = (state_q == dps_pkg::ST_IDLE);
  assign ctrl_o.load_out = (state_q == dps_pkg::ST_OUT) && out_free_i;

endmodule

FILE: hw/rtl/drive_distance_pd_step_core.sv
// Top level: distance/heading PD drive step with slew-limited drive power.
// The sequencer walks one shared 27x28 multiplier through the division and five
// products for a control tick; a start word skips the products. It takes a new word
// only once the last result has been loaded into the output register.
// Reset: async active low; gains and targets take their defaults, slew limit 80,
// latched errors zero, no result pending.
module drive_distance_pd_step_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [dps_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [dps_pkg::CfgW-1:0]             cfg_wdata_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic signed [dps_pkg::PosW-1:0]      pos_left_a_i,
  input  logic signed [dps_pkg::PosW-1:0]      pos_left_b_i,
  input  logic signed [dps_pkg::PosW-1:0]      pos_left_c_i,
  input  logic signed [dps_pkg::PosW-1:0]      pos_right_a_i,
  input  logic signed [dps_pkg::PosW-1:0]      pos_right_b_i,
  input  logic signed [dps_pkg::PosW-1:0]      pos_right_c_i,
  input  logic signed [dps_pkg::HeadW-1:0]     heading_now_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dps_pkg::VoltW-1:0]     left_volts_o,
  output logic signed [dps_pkg::VoltW-1:0]     right_volts_o,
  output logic                                 done_res_o,
  output logic signed [dps_pkg::ErrW-1:0]      distance_error_o
);

  localparam int unsigned AccW  = dps_pkg::AccW;
  localparam int unsigned PowW  = dps_pkg::PowW;
  localparam int unsigned PsumW = dps_pkg::PsumW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [dps_pkg::CfgW-1:0]  tgt_dist_q;
  logic signed [dps_pkg::HeadW-1:0] tgt_head_q;
  logic [dps_pkg::GainW-1:0]        gain_pd_q, gain_dd_q, gain_ph_q, gain_dh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_dist_q <= '0;
      tgt_head_q <= '0;
      gain_pd_q  <= dps_pkg::GainPDistRst;
      gain_dd_q  <= dps_pkg::GainDDistRst;
      gain_ph_q  <= dps_pkg::GainPHeadRst;
      gain_dh_q  <= dps_pkg::GainDHeadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dps_pkg::REG_TGT_DIST: tgt_dist_q <= cfg_wdata_i;
        dps_pkg::REG_TGT_HEAD: tgt_head_q <= cfg_wdata_i[dps_pkg::HeadW-1:0];
        dps_pkg::REG_GAIN_PD:  gain_pd_q  <= cfg_wdata_i[dps_pkg::GainW-1:0];
        dps_pkg::REG_GAIN_DD:  gain_dd_q  <= cfg_wdata_i[dps_pkg::GainW-1:0];
        dps_pkg::REG_GAIN_PH:  gain_ph_q  <= cfg_wdata_i[dps_pkg::GainW-1:0];
        dps_pkg::REG_GAIN_DH:  gain_dh_q  <= cfg_wdata_i[dps_pkg::GainW-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  dps_pkg::dps_ctrl_t ctrl;
  logic               out_valid_q;
  logic               out_free;
  logic               kind_q;

  assign out_free = !out_valid_q || out_ready_i;

  dps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .tick_i     (kind_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o = ctrl.ready;

  // ---------------------------------------------------------------------------
  // Shared multiplier and operand select
  // ---------------------------------------------------------------------------
  logic signed [dps_pkg::PosW-1:0]  pos_q [6];
  logic signed [dps_pkg::HeadW-1:0] head_q;
  logic signed [dps_pkg::SumW-1:0]  sum_q, sum_abs;
  logic signed [dps_pkg::ErrW-1:0]  err_q;
  logic signed [dps_pkg::TerrW-1:0] terr_q;
  logic signed [dps_pkg::DiffW-1:0] d_q;
  logic signed [dps_pkg::TdW-1:0]   td_q;
  logic [dps_pkg::Kp2W-1:0]         kp2_q;
  logic signed [dps_pkg::MulAW-1:0] mul_a;
  logic signed [dps_pkg::MulBW-1:0] mul_b;
  logic signed [dps_pkg::ProdW-1:0] prod;

  assign sum_abs = sum_q[dps_pkg::SumW-1] ? -sum_q : sum_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.state)
      dps_pkg::ST_DIV: begin
        mul_a = sum_abs;
        mul_b = dps_pkg::DivSixRecip;
      end
      dps_pkg::ST_M1: begin
        mul_a = {{2{err_q[dps_pkg::ErrW-1]}}, err_q};
        mul_b = {12'b0, gain_pd_q};
      end
      dps_pkg::ST_M2: begin
        mul_a = {d_q[dps_pkg::DiffW-1], d_q};
        mul_b = {12'b0, gain_dd_q};
      end
      dps_pkg::ST_M3: begin
        mul_a = {{2{err_q[dps_pkg::ErrW-1]}}, err_q};
        mul_b = {18'b0, kp2_q};
      end
      dps_pkg::ST_M4: begin
        mul_a = {{10{terr_q[dps_pkg::TerrW-1]}}, terr_q};
        mul_b = {12'b0, gain_ph_q};
      end
      dps_pkg::ST_M5: begin
        mul_a = {{9{td_q[dps_pkg::TdW-1]}}, td_q};
        mul_b = {12'b0, gain_dh_q};
      end
      default: ;
    endcase
  end

  dps_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // Q34.12 to integer, truncating toward zero
  function automatic logic signed [PowW-1:0] trunc_frac(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] t;
    t = x + (x[AccW-1] ? AccW'(4095) : AccW'(0));
    return t[AccW-1:dps_pkg::FracW];
  endfunction

  // p*12/100 truncated, saturated to +/-12; |p| <= 108 uses floor(|p|*123/1024)
  function automatic logic signed [dps_pkg::VoltW-1:0] to_volts(
      input logic signed [PsumW-1:0] p);
    logic [6:0]                  m;
    logic [13:0]                 pr;
    logic [dps_pkg::VoltW-1:0]   v;
    m  = p[PsumW-1] ? 7'(-p) : 7'(p);
    pr = 14'(m) * 14'd123;
    v  = {1'b0, pr[13:10]};
    if (p >= 35'sd109)       return 5'sd12;
    else if (p <= -35'sd109) return -5'sd12;
    else                     return p[PsumW-1] ? -v : v;
  endfunction

  // ---------------------------------------------------------------------------
  // Error stage combinational terms
  // ---------------------------------------------------------------------------
  logic [dps_pkg::ErrW-1:0]         quot;
  logic signed [dps_pkg::ErrW-1:0]  avg;
  logic signed [dps_pkg::DiffW-1:0] err_wide;
  logic signed [dps_pkg::ErrW-1:0]  last_d_q;
  logic signed [dps_pkg::TdW-1:0]   last_h_q;
  logic [dps_pkg::SlewW-1:0]        slew_q;
  logic [dps_pkg::ErrW-1:0]         abs_err;
  logic                             d_zero;
  logic [dps_pkg::Kp2W-1:0]         kp2_d;
  logic signed [dps_pkg::SumW-1:0]  sum_d;

  assign sum_d = dps_pkg::SumW'(pos_q[0]) + dps_pkg::SumW'(pos_q[1])
               + dps_pkg::SumW'(pos_q[2]) + dps_pkg::SumW'(pos_q[3])
               + dps_pkg::SumW'(pos_q[4]) + dps_pkg::SumW'(pos_q[5]);

  assign quot     = prod[dps_pkg::DivSixShift+dps_pkg::ErrW-1:dps_pkg::DivSixShift];
  assign avg      = sum_q[dps_pkg::SumW-1] ? -$signed(quot) : $signed(quot);
  assign err_wide = dps_pkg::DiffW'(tgt_dist_q) - dps_pkg::DiffW'(avg);

  assign abs_err = err_q[dps_pkg::ErrW-1] ? -err_q : err_q;
  assign d_zero  = (err_q == last_d_q);

  // Band gain: far side first, then mid and near bands only when settled
  always_comb begin
    if (err_q > 25'sd250)
      kp2_d = dps_pkg::Kp2Far;
    else if (abs_err > 25'd20 && d_zero && abs_err < 25'd250)
      kp2_d = dps_pkg::Kp2Mid;
    else if (abs_err > 25'd5 && d_zero && abs_err < 25'd20)
      kp2_d = dps_pkg::Kp2Near;
    else
      kp2_d = '0;
  end

  // ---------------------------------------------------------------------------
  // Controller state: latched errors and slew limit
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_d_q <= '0;
      last_h_q <= '0;
      slew_q   <= dps_pkg::SlewStart;
    end else if (ctrl.state == dps_pkg::ST_DIFF) begin
      last_d_q <= err_q;
      last_h_q <= dps_pkg::TdW'(terr_q);
      if (!kind_q)
        slew_q <= dps_pkg::SlewStart;
      else if (slew_q > dps_pkg::SlewMax - dps_pkg::SlewStep)
        slew_q <= dps_pkg::SlewMax;
      else
        slew_q <= slew_q + dps_pkg::SlewStep;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0]  acc_q;
  logic                    sat_q;
  logic                    done_q;
  logic signed [PowW-1:0]  pw_q, tpw_q;
  logic signed [PsumW-1:0] psum_l_q, psum_r_q;
  logic signed [AccW-1:0]  prod_acc;
  logic signed [AccW-1:0]  slew_fix;

  assign prod_acc = prod[AccW-1:0];
  assign slew_fix = $signed({{(AccW-dps_pkg::SlewW-dps_pkg::FracW){1'b0}}, slew_q,
                             {dps_pkg::FracW{1'b0}}});

  always_ff @(posedge clk_i) begin
    case (ctrl.state)
      dps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_q   <= kind_i;
          pos_q[0] <= pos_left_a_i;
          pos_q[1] <= pos_left_b_i;
          pos_q[2] <= pos_left_c_i;
          pos_q[3] <= pos_right_a_i;
          pos_q[4] <= pos_right_b_i;
          pos_q[5] <= pos_right_c_i;
          head_q   <= heading_now_i;
        end
      end
      dps_pkg::ST_SUM: begin
        sum_q  <= sum_d;
        terr_q <= dps_pkg::TerrW'(tgt_head_q) - dps_pkg::TerrW'(head_q);
      end
      dps_pkg::ST_ERR: err_q <= err_wide[dps_pkg::ErrW-1:0];
      dps_pkg::ST_DIFF: begin
        d_q    <= dps_pkg::DiffW'(err_q) - dps_pkg::DiffW'(last_d_q);
        td_q   <= last_h_q - dps_pkg::TdW'(terr_q);
        kp2_q  <= kp2_d;
        // a start word counts its difference as zero
        done_q <= (abs_err <= 25'd15) && (d_zero || !kind_q);
      end
      dps_pkg::ST_M2: acc_q <= prod_acc;                   // err*Kp
      dps_pkg::ST_M3: acc_q <= acc_q + prod_acc;           // + d*Kd
      dps_pkg::ST_M4: begin
        sat_q <= (acc_q > slew_fix);                       // cap test without band gain
        acc_q <= acc_q + prod_acc;                         // + err*Kp2
      end
      dps_pkg::ST_M5: begin
        pw_q  <= sat_q ? PowW'(slew_q) : trunc_frac(acc_q);
        acc_q <= prod_acc;                                 // terr*Kp heading
      end
      dps_pkg::ST_M6: acc_q <= acc_q + prod_acc;           // + td*Kd heading
      dps_pkg::ST_TRN: begin
        tpw_q <= (acc_q > AccW'(40 * 4096)) ? PowW'(40) : trunc_frac(acc_q);
      end
      dps_pkg::ST_VOLT: begin
        psum_l_q <= PsumW'(pw_q) + PsumW'(tpw_q);
        psum_r_q <= PsumW'(pw_q) - PsumW'(tpw_q);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: holds the result while the next word is taken in
  // ---------------------------------------------------------------------------
  logic signed [dps_pkg::VoltW-1:0] lv_q, rv_q;
  logic                             done_out_q;
  logic signed [dps_pkg::ErrW-1:0]  dist_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      lv_q       <= kind_q ? to_volts(psum_l_q) : '0;
      rv_q       <= kind_q ? to_volts(psum_r_q) : '0;
      done_out_q <= done_q;
      dist_out_q <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_volts_o     = lv_q;
  assign right_volts_o    = rv_q;
  assign done_res_o       = done_out_q;
  assign distance_error_o = dist_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer still ready after taking a word");

  a_volts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_volts_o <= 5'sd12 && left_volts_o >= -5'sd12 &&
                     right_volts_o <= 5'sd12 && right_volts_o >= -5'sd12))
    else $error("volts outside saturation range");

  a_done_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |->
      (distance_error_o <= 25'sd15 && distance_error_o >= -25'sd15))
    else $error("done raised with error outside band");

  a_slew_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slew_q >= dps_pkg::SlewStart)
    else $error("slew limit below start value");

endmodule

FILE: tb/drive_step_tb_pkg.sv
// Testbench types, constants and the scoreboard that predicts and checks volts words.
`timescale 1ns / 1ps

package drive_step_tb_pkg;
  import dps_pkg::*;

  localparam longint SlewInit  = SlewStart;
  localparam longint SlewIncr  = SlewStep;
  localparam longint SlewCap   = SlewMax;
  localparam longint Kp2FarQ   = Kp2Far;
  localparam longint Kp2MidQ   = Kp2Mid;
  localparam longint Kp2NearQ  = Kp2Near;
  localparam longint FracOne   = longint'(1) << FracW;
  localparam longint TurnCap   = 40;
  localparam longint DoneBand  = 15;
  localparam longint FarBand   = 250;
  localparam longint MidBand   = 20;
  localparam longint NearBand  = 5;
  localparam longint VoltMax   = 12;
  localparam longint VoltScale = 100;
  localparam longint PosMax    = (longint'(1) << (PosW - 1)) - 1;
  localparam longint PosMin    = -PosMax - 1;
  localparam longint HeadMax   = (longint'(1) << (HeadW - 1)) - 1;
  localparam longint HeadMin   = -HeadMax - 1;
  localparam longint DistMax   = (longint'(1) << (CfgW - 1)) - 1;
  localparam longint DistMin   = -DistMax - 1;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } word_kind_e;

  typedef struct {
    word_kind_e              kind;
    logic signed [PosW-1:0]  pos [6];
    logic signed [HeadW-1:0] heading;
  } drive_word_t;

  typedef struct packed {
    logic signed [VoltW-1:0] left;
    logic signed [VoltW-1:0] right;
    logic                    done;
    logic signed [ErrW-1:0]  dist_err;
  } volts_word_t;

  class volts_scoreboard;
    longint      tgt_dist, tgt_head;
    longint      kp_dist, kd_dist, kp_head, kd_head;
    longint      prev_err, prev_terr, slew;
    volts_word_t pending_volts [$];
    int unsigned n_checked, n_errors;

    function new();
      tgt_dist  = 0;
      tgt_head  = 0;
      kp_dist   = GainPDistRst;
      kd_dist   = GainDDistRst;
      kp_head   = GainPHeadRst;
      kd_head   = GainDHeadRst;
      prev_err  = 0;
      prev_terr = 0;
      slew      = SlewInit;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void write_reg(dps_reg_e idx, logic [CfgW-1:0] data);
      case (idx)
        REG_TGT_DIST: tgt_dist = $signed(data);
        REG_TGT_HEAD: tgt_head = $signed(data[HeadW-1:0]);
        REG_GAIN_PD:  kp_dist  = data[GainW-1:0];
        REG_GAIN_DD:  kd_dist  = data[GainW-1:0];
        REG_GAIN_PH:  kp_head  = data[GainW-1:0];
        REG_GAIN_DH:  kd_head  = data[GainW-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [VoltW-1:0] volts_of(longint p);
      longint v;
      v = p * VoltMax / VoltScale;
      if (v > VoltMax) v = VoltMax;
      if (v < -VoltMax) v = -VoltMax;
      return VoltW'(v);
    endfunction

    // Work out the volts word for one accepted drive word and queue it.
    function void note_word(drive_word_t w);
      longint      sum, err, terr, mag_err, d, td, kp2, acc, pw, tq, tpw;
      volts_word_t r;
      sum = 0;
      for (int i = 0; i < 6; i++) sum += w.pos[i];
      err     = tgt_dist - sum / 6;
      terr    = tgt_head - w.heading;
      mag_err = (err < 0) ? -err : err;
      r.left  = '0;
      r.right = '0;
      if (w.kind == KIND_START) begin
        slew   = SlewInit;
        r.done = (mag_err <= DoneBand);
      end else begin
        slew = (slew + SlewIncr > SlewCap) ? SlewCap : slew + SlewIncr;
        d    = err - prev_err;
        td   = prev_terr - terr;
        if (err > FarBand) kp2 = Kp2FarQ;
        else if (mag_err > MidBand && d == 0 && mag_err < FarBand) kp2 = Kp2MidQ;
        else if (mag_err > NearBand && d == 0 && mag_err < MidBand) kp2 = Kp2NearQ;
        else kp2 = 0;
        acc = err * kp_dist + d * kd_dist;
        if (acc > slew * FracOne) pw = slew;
        else pw = (err * (kp_dist + kp2) + d * kd_dist) / FracOne;
        tq  = terr * kp_head + td * kd_head;
        tpw = (tq > TurnCap * FracOne) ? TurnCap : tq / FracOne;
        r.left  = volts_of(pw + tpw);
        r.right = volts_of(pw - tpw);
        r.done  = (mag_err <= DoneBand) && (d == 0);
      end
      prev_err   = err;
      prev_terr  = terr;
      r.dist_err = ErrW'(err);
      pending_volts.push_back(r);
    endfunction

    function void report(string field, logic signed [ErrW-1:0] want,
                         logic signed [ErrW-1:0] got);
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      n_errors++;
    endfunction

    function void check_volts(volts_word_t got);
      volts_word_t want;
      if (pending_volts.size() == 0) begin
        $display("%0t: unexpected volts word: expected none, got %0d/%0d/%0b/%0d", $time,
                 got.left, got.right, got.done, got.dist_err);
        n_errors++;
        return;
      end
      want = pending_volts.pop_front();
      n_checked++;
      if (got.left !== want.left) report("left_volts", want.left, got.left);
      if (got.right !== want.right) report("right_volts", want.right, got.right);
      if (got.done !== want.done) report("done_res", want.done, got.done);
      if (got.dist_err !== want.dist_err) report("distance_error", want.dist_err, got.dist_err);
    endfunction
  endclass

endpackage

FILE: tb/drive_distance_pd_step_core_tb.sv
// Top-level testbench for the drive distance PD step core.
`timescale 1ns / 1ps

module drive_distance_pd_step_core_tb;
  import dps_pkg::*;
  import drive_step_tb_pkg::*;

  localparam int unsigned StallLimit   = 2000;  // cycles with no word moving
  localparam int unsigned SettleCycles = 30;    // tail after the last result, > tick latency
  localparam int unsigned RandomItems  = 460;
  localparam int unsigned PhaseItems   = 110;   // random words per register setting
  localparam int unsigned SlewRunTicks = 60;    // ticks in the unbroken capped run

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CfgW-1:0]         cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    kind_i;
  logic signed [PosW-1:0]  pos_i [6];
  logic signed [HeadW-1:0] heading_now_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VoltW-1:0] left_volts_o;
  logic signed [VoltW-1:0] right_volts_o;
  logic                    done_res_o;
  logic signed [ErrW-1:0]  distance_error_o;

  volts_scoreboard sb;
  bit              steady_flow;  // both sides stop idling while set
  int unsigned     n_words, n_starts, n_phases;

  drive_distance_pd_step_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .pos_left_a_i     (pos_i[0]),
    .pos_left_b_i     (pos_i[1]),
    .pos_left_c_i     (pos_i[2]),
    .pos_right_a_i    (pos_i[3]),
    .pos_right_b_i    (pos_i[4]),
    .pos_right_c_i    (pos_i[5]),
    .heading_now_i    (heading_now_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_volts_o     (left_volts_o),
    .right_volts_o    (right_volts_o),
    .done_res_o       (done_res_o),
    .distance_error_o (distance_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Uniform in [-lim, lim].
  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  // Gain value with junk above bit 15, which the block must ignore.
  function automatic logic [CfgW-1:0] pad_gain(logic [GainW-1:0] g);
    return {(CfgW - GainW)'($urandom()), g};
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    return ($urandom_range(1) == 1) ? GainW'($urandom()) : GainW'($urandom_range(4096));
  endfunction

  // Error values on and either side of each band edge, random sign.
  function automatic longint band_edge();
    longint e;
    case ($urandom_range(3))
      0:       e = NearBand;
      1:       e = DoneBand;
      2:       e = MidBand;
      default: e = FarBand;
    endcase
    e = e + rand_span(1);
    return ($urandom_range(1) == 1) ? e : -e;
  endfunction

  function automatic longint pick_error();
    case ($urandom_range(4))
      0:       return rand_span(30);
      1:       return rand_span(400);
      2:       return rand_span(8000);
      3:       return rand_span(longint'(1) << 21);
      default: return band_edge();
    endcase
  endfunction

  function automatic drive_word_t flat_word(word_kind_e kind, logic signed [PosW-1:0] p,
                                            logic signed [HeadW-1:0] h);
    drive_word_t w;
    w.kind = kind;
    for (int i = 0; i < 6; i++) w.pos[i] = p;
    w.heading = h;
    return w;
  endfunction

  // Word whose six-position average lands the distance error exactly on dist_err
  // for the current target; positions scatter about the mean by a random spread, which may be zero.
  function automatic drive_word_t shaped_word(word_kind_e kind, longint dist_err,
                                              longint head_err);
    drive_word_t w;
    longint      base, spread, dev_sum, r, hd;
    base = sb.tgt_dist - dist_err;
    case ($urandom_range(3))
      0:       spread = 0;
      1, 2:    spread = 200;
      default: spread = 200000;
    endcase
    dev_sum = 0;
    for (int i = 1; i < 6; i++) begin
      r        = rand_span(spread);
      dev_sum += r;
      w.pos[i] = PosW'(base + r);
    end
    // remainder keeps the sign of the sum, so truncation still gives base
    if (base > 0) r = $urandom_range(5);
    else if (base < 0) r = -longint'($urandom_range(5));
    else r = rand_span(5);
    w.pos[0] = PosW'(base - dev_sum + r);
    hd = sb.tgt_head - head_err;
    if (hd > HeadMax) hd = HeadMax;
    if (hd < HeadMin) hd = HeadMin;
    w.kind    = kind;
    w.heading = HeadW'(hd);
    return w;
  endfunction

  function automatic drive_word_t noise_word();
    drive_word_t w;
    w.kind = word_kind_e'($urandom_range(1));
    for (int i = 0; i < 6; i++) w.pos[i] = PosW'($urandom());
    w.heading = HeadW'($urandom());
    return w;
  endfunction

  task automatic idle_input(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Present one drive word and hold it until the block takes it.
  task automatic send_word(drive_word_t w);
    if (!steady_flow && $urandom_range(99) < 30) idle_input($urandom_range(20, 1));
    in_valid_i    <= 1'b1;
    kind_i        <= w.kind;
    for (int i = 0; i < 6; i++) pos_i[i] <= w.pos[i];
    heading_now_i <= w.heading;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    n_words++;
    if (w.kind == KIND_START) n_starts++;
  endtask

  // Hold off the sender until every outstanding volts word has been taken.
  task automatic drain();
    idle_input(1);
    while (sb.pending_volts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last register.
  task automatic write_reg(dps_reg_e idx, logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic reconfigure(logic [CfgW-1:0] tdist, logic [CfgW-1:0] thead,
                             logic [CfgW-1:0] kpd, logic [CfgW-1:0] kdd,
                             logic [CfgW-1:0] kph, logic [CfgW-1:0] kdh);
    drain();
    write_reg(REG_TGT_DIST, tdist);
    write_reg(REG_TGT_HEAD, thead);
    write_reg(REG_GAIN_PD, kpd);
    write_reg(REG_GAIN_DD, kdd);
    write_reg(REG_GAIN_PH, kph);
    write_reg(REG_GAIN_DH, kdh);
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  // A start word followed by a run of ticks homing in on the target. Holding the
  // error steady gives a zero difference, which opens the mid and near bands.
  task automatic run_sequence();
    longint      e, te;
    int unsigned n_ticks, roll;
    e  = pick_error();
    te = ($urandom_range(9) == 0) ? rand_span(40000) : rand_span(100);
    send_word(shaped_word(KIND_START, e, te));
    n_ticks = $urandom_range(14, 1);
    repeat (n_ticks) begin
      roll = $urandom_range(99);
      if (roll < 35) e = e;
      else if (roll < 50) e = band_edge();
      else e = e - e / 3 + rand_span(3);
      te = te - te / 4 + rand_span(2);
      send_word(shaped_word(KIND_TICK, e, te));
    end
  endtask

  // Result side: takes volts words with random back-pressure and checks each one.
  initial begin : result_sink
    volts_word_t got;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.left     = left_volts_o;
        got.right    = right_volts_o;
        got.done     = done_res_o;
        got.dist_err = distance_error_o;
        sb.check_volts(got);
      end
      out_ready_i <= steady_flow || ($urandom_range(99) >= 30);
    end
  end

  // Ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, StallLimit);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    longint      band_walk [18];
    drive_word_t w;
    int unsigned rand_first, next_cfg;
    sb          = new();
    steady_flow = 1'b0;
    n_words     = 0;
    n_starts    = 0;
    n_phases    = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_TGT_DIST;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_START;
    for (int i = 0; i < 6; i++) pos_i[i] <= '0;
    heading_now_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed, reset register values ---
    // ticks before any start word run on the reset state
    send_word(flat_word(KIND_TICK, '0, '0));
    send_word(flat_word(KIND_TICK, PosW'(PosMax), HeadW'(HeadMin)));
    send_word(flat_word(KIND_TICK, PosW'(PosMin), HeadW'(HeadMax)));
    // average of -7/6 must truncate towards zero, not floor
    w = flat_word(KIND_START, '0, '0);
    w.pos[0] = -7;
    send_word(w);
    w.kind = KIND_TICK;
    send_word(w);
    // walk the error across every band edge, most values twice for a zero difference
    band_walk = '{300, 300, 250, 250, 249, 249, 20, 20, 19, 19, 6, 6, 5, 15, 16,
                  -300, -100, -100};
    foreach (band_walk[i])
      send_word(shaped_word((i == 0) ? KIND_START : KIND_TICK, band_walk[i], rand_span(50)));

    // --- directed, extreme register settings ---
    reconfigure(CfgW'(DistMax), {(CfgW - HeadW)'($urandom()), HeadW'(HeadMin)},
                pad_gain('1), pad_gain('1), pad_gain('1), pad_gain('1));
    send_word(flat_word(KIND_START, PosW'(PosMin), HeadW'(HeadMax)));
    send_word(flat_word(KIND_TICK, PosW'(PosMax), HeadW'(HeadMin)));
    reconfigure(CfgW'(DistMin), {(CfgW - HeadW)'($urandom()), HeadW'(HeadMax)},
                pad_gain('0), pad_gain('0), pad_gain('0), pad_gain('0));
    send_word(flat_word(KIND_TICK, '0, '0));
    send_word(flat_word(KIND_START, PosW'(PosMax), HeadW'(HeadMin)));

    // --- random: mostly well-formed sequences, some noise words ---
    rand_first = n_words;
    next_cfg   = n_words;
    while (n_words < rand_first + RandomItems) begin
      if (n_words >= next_cfg) begin
        reconfigure(CfgW'($urandom()), CfgW'($urandom()), pad_gain(rand_gain()),
                    pad_gain(rand_gain()), pad_gain(rand_gain()), pad_gain(rand_gain()));
        next_cfg = n_words + PhaseItems;
      end
      if ($urandom_range(99) < 85) run_sequence();
      else send_word(noise_word());
    end

    // --- long tick run without idling: drive power held at the climbing slew limit ---
    // Full distance gain keeps the drive power capped; turn gain 1.0 with a heading
    // error of -65535 swamps it on most ticks, a small heading error on the rest.
    steady_flow = 1'b1;
    reconfigure(CfgW'(DistMax), {(CfgW - HeadW)'($urandom()), HeadW'(HeadMin)},
                pad_gain('1), pad_gain('0), pad_gain(GainW'(FracOne)), pad_gain('0));
    send_word(shaped_word(KIND_START, 600000, 0));
    repeat (SlewRunTicks) begin
      w = shaped_word(KIND_TICK, 400000 + longint'($urandom_range(600000)), rand_span(200));
      if ($urandom_range(99) < 80) w.heading = HeadW'(HeadMax);
      send_word(w);
    end
    steady_flow = 1'b0;

    // --- wind down ---
    idle_input(1);
    while (sb.pending_volts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d drive words (%0d start words) under %0d register settings, %0d volts checked",
             n_words, n_starts, n_phases, sb.n_checked);
    $display("error bands, field extremes, truncated averages and a capped tick run exercised");
    if (sb.n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
